@@ rtl/core/scba_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the size-class bucket allocator.
package scba_pkg;

   localparam int POOL_BYTES   = 65536;
   localparam int NUM_CLASSES  = 9;
   localparam int HEADER_BYTES = 32;
   localparam int GRANULES     = POOL_BYTES / 16;
   localparam int GRAN_W       = $clog2(GRANULES);
   localparam int CLASS_W      = 4;
   localparam int BUMP_W       = $clog2(POOL_BYTES) + 1;
   localparam int OFF_W        = 16;
   localparam int TOTAL_W      = 17;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_EXHAUSTED = 3'd3;
   localparam logic [2:0] ST_BAD_PTR   = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Header tag kept as a code: unused, allocated, free.
   localparam logic [1:0] TAG_NONE = 2'd0;
   localparam logic [1:0] TAG_USED = 2'd1;
   localparam logic [1:0] TAG_FREE = 2'd2;

   typedef struct packed {
      logic [1:0]         tag;
      logic [CLASS_W-1:0] cls;
      logic [GRAN_W-1:0]  next;
      logic               next_valid;
   } slot_entry_type;

   typedef struct packed {
      logic               too_large;
      logic [CLASS_W-1:0] cls;
   } class_pick_type;

   // Smallest class whose slot (16 << cls) holds the total.
   function automatic class_pick_type pick_class(input logic [TOTAL_W-1:0] total);
      class_pick_type res;
      res.too_large = 1'b1;
      res.cls       = '0;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (total <= (TOTAL_W'(16) << i)) begin
            res.too_large = 1'b0;
            res.cls       = CLASS_W'(i);
         end
      end
      return res;
   endfunction

endpackage

@@ rtl/core/scba_slot_ram.sv @@
`timescale 1ns / 1ps
// Per-granule slot store: header tag, class and free-list link, registered read.
module scba_slot_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [scba_pkg::GRAN_W-1:0]    wr_addr,
   input  scba_pkg::slot_entry_type       wr_data,
   input  logic                           rd_en,
   input  logic [scba_pkg::GRAN_W-1:0]    rd_addr,
   output scba_pkg::slot_entry_type       rd_data
);

   scba_pkg::slot_entry_type mem [scba_pkg::GRANULES];
   scba_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/size_class_bucket_allocator.sv @@
`timescale 1ns / 1ps
// Size-class bucket allocator top level: request decode, free lists, bump carve, response.
//
// Allocator over a 64 KiB byte pool with nine power-of-two size classes (16 to 4096 byte
// slots). An allocate transaction adds the 32-byte header to req_bytes, picks the smallest
// class that holds it, pops that class's LIFO free list or else carves a fresh slot from
// the bump pointer, and returns the payload offset (slot start + 32). A free transaction
// checks the header tag of the slot at payload_offset - 32 and pushes it onto its class
// list. The accept edge issues one read of the slot store (free-list head or freed header),
// and the write-back edge that follows does the write-back, the head update and loads the
// response register; the next request is accepted only after that edge, so the allocator
// never takes a new request before the last one is written back. While the response
// register holds a result that has not been taken, one more request can be accepted, but
// its write-back edge waits for rsp_ready and req_ready stays low until it completes.
// After reset the slot store is cleared one entry per cycle, during which req_ready stays low.
module size_class_bucket_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [15:0]                     req_req_bytes,
   input  logic [15:0]                     req_payload_offset,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_status,
   output logic [15:0]                     rsp_granted_offset,
   output logic [3:0]                      rsp_size_class
);

   localparam int GW = scba_pkg::GRAN_W;
   localparam int CW = scba_pkg::CLASS_W;
   localparam int BW = scba_pkg::BUMP_W;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [GW-1:0] clr_cnt_ff, clr_cnt_in;

   // Free-list heads, one per class
   logic [GW-1:0]                   head_g_ff [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::NUM_CLASSES-1:0] head_v_ff;
   logic [BW-1:0]                   bump_ff, bump_in;

   // Latched request
   logic          op_ff;
   logic          zero_ff, large_ff, null_ff, badaddr_ff, use_list_ff;
   logic [CW-1:0] cls_ff;
   logic [GW-1:0] g_ff;

   // Response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff;
   logic [15:0]   granted_ff;
   logic [CW-1:0] rcls_ff;

   // Slot store port signals
   logic                     wr_en;
   logic [GW-1:0]            wr_addr;
   scba_pkg::slot_entry_type wr_data;
   logic [GW-1:0]            rd_addr;
   scba_pkg::slot_entry_type rd_data;

   logic                         accept, exec_go;
   logic [scba_pkg::TOTAL_W-1:0] total;
   scba_pkg::class_pick_type     pick;
   logic [15:0]                  start_off;

   // Shared head read port: request class at accept, freed slot's class in exec
   logic [CW-1:0] head_idx;
   logic [GW-1:0] head_g_rd;
   logic          head_v_rd;

   // Exec-stage decisions
   logic                slot_fit;
   logic [BW-1:0]       slot_bytes;
   logic [BW:0]         bump_sum;
   logic                head_upd;
   logic [CW-1:0]       head_upd_idx;
   logic [GW-1:0]       head_upd_g;
   logic                head_upd_v;
   logic [2:0]          status_in;
   logic [15:0]         granted_in;
   logic [CW-1:0]       rcls_in;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign exec_go   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign total     = {1'b0, req_req_bytes} + scba_pkg::TOTAL_W'(scba_pkg::HEADER_BYTES);
   assign pick      = scba_pkg::pick_class(total);
   assign start_off = req_payload_offset - 16'(scba_pkg::HEADER_BYTES);

   assign head_idx = (state_ff == S_EXEC) ? rd_data.cls : pick.cls;

   always_comb begin
      head_g_rd = '0;
      head_v_rd = 1'b0;
      if (head_idx < CW'(scba_pkg::NUM_CLASSES)) begin
         head_g_rd = head_g_ff[head_idx];
         head_v_rd = head_v_ff[head_idx];
      end
   end

   // Read address issued at accept: class head for allocate, header granule for free
   assign rd_addr = (req_op == scba_pkg::OP_ALLOC) ? head_g_rd : start_off[15:4];

   scba_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         zero_ff     <= (req_req_bytes == 16'd0);
         large_ff    <= pick.too_large;
         cls_ff      <= pick.cls;
         use_list_ff <= head_v_rd;
         null_ff     <= (req_payload_offset == 16'd0);
         badaddr_ff  <= (req_payload_offset < 16'(scba_pkg::HEADER_BYTES))
                        || (req_payload_offset[3:0] != 4'd0);
         g_ff        <= (req_op == scba_pkg::OP_ALLOC) ? head_g_rd : start_off[15:4];
      end
   end

   assign slot_bytes = BW'(16) << cls_ff;
   assign bump_sum   = {1'b0, bump_ff} + {1'b0, slot_bytes};
   assign slot_fit   = (bump_sum <= (BW + 1)'(scba_pkg::POOL_BYTES));

   // Exec stage: write-back, head and bump update, response
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = g_ff;
      wr_data      = '0;
      head_upd     = 1'b0;
      head_upd_idx = cls_ff;
      head_upd_g   = '0;
      head_upd_v   = 1'b0;
      bump_in      = bump_ff;
      status_in    = scba_pkg::ST_OK;
      granted_in   = '0;
      rcls_in      = '0;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
      end else if (exec_go) begin
         if (op_ff == scba_pkg::OP_ALLOC) begin
            if (zero_ff) begin
               status_in = scba_pkg::ST_ZERO_SIZE;
            end else if (large_ff) begin
               status_in = scba_pkg::ST_TOO_LARGE;
            end else if (use_list_ff) begin
               // Pop the free-list head
               wr_en          = 1'b1;
               wr_addr        = g_ff;
               wr_data.tag    = scba_pkg::TAG_USED;
               wr_data.cls    = cls_ff;
               head_upd       = 1'b1;
               head_upd_g     = rd_data.next;
               head_upd_v     = rd_data.next_valid;
               granted_in     = {g_ff, 4'd0} + 16'(scba_pkg::HEADER_BYTES);
               rcls_in        = cls_ff;
            end else if (slot_fit) begin
               // Carve from the bump pointer
               wr_en       = 1'b1;
               wr_addr     = bump_ff[GW+3:4];
               wr_data.tag = scba_pkg::TAG_USED;
               wr_data.cls = cls_ff;
               bump_in     = bump_sum[BW-1:0];
               granted_in  = {bump_ff[GW+3:4], 4'd0} + 16'(scba_pkg::HEADER_BYTES);
               rcls_in     = cls_ff;
            end else begin
               status_in = scba_pkg::ST_EXHAUSTED;
               rcls_in   = cls_ff;
            end
         end else begin
            if (null_ff) begin
               status_in = scba_pkg::ST_OK;
            end else if (badaddr_ff || (rd_data.tag != scba_pkg::TAG_USED)
                         || (rd_data.cls >= CW'(scba_pkg::NUM_CLASSES))) begin
               status_in = scba_pkg::ST_BAD_PTR;
            end else begin
               // Push onto the class list
               wr_en              = 1'b1;
               wr_addr            = g_ff;
               wr_data.tag        = scba_pkg::TAG_FREE;
               wr_data.cls        = rd_data.cls;
               wr_data.next       = head_g_rd;
               wr_data.next_valid = head_v_rd;
               head_upd           = 1'b1;
               head_upd_idx       = rd_data.cls;
               head_upd_g         = g_ff;
               head_upd_v         = 1'b1;
               rcls_in            = rd_data.cls;
            end
         end
      end
   end

   // Control state machine
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + GW'(1);
            if (clr_cnt_ff == GW'(scba_pkg::GRANULES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         bump_ff      <= '0;
         head_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_upd) begin
            head_v_ff[head_upd_idx] <= head_upd_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_upd) begin
         head_g_ff[head_upd_idx] <= head_upd_g;
      end
      if (exec_go) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         rcls_ff    <= rcls_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_offset = granted_ff;
   assign rsp_size_class     = rcls_ff;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the size-class bucket allocator.
module tb;

   // Offsets are 16 bits wide, so the usable pool never exceeds 64 KiB.
   localparam int EFF_POOL = (scba_pkg::POOL_BYTES < 65536) ? scba_pkg::POOL_BYTES : 65536;

   // Expected fields of one response transaction.
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] offset;
      logic [3:0]  cls;
   } outcome_type;

   // Clock, reset and DUT ports. Every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = scba_pkg::OP_ALLOC;
   logic [15:0] req_req_bytes = '0;
   logic [15:0] req_payload_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_granted_offset;
   logic [3:0]  rsp_size_class;

   // Allocator mirror. bit types start at zero: every tag unused, every list empty.
   bit [1:0]                  gran_tag      [scba_pkg::GRANULES];
   bit [3:0]                  gran_cls      [scba_pkg::GRANULES];
   bit [scba_pkg::GRAN_W-1:0] gran_link     [scba_pkg::GRANULES];
   bit                        gran_link_ok  [scba_pkg::GRANULES];
   bit [scba_pkg::GRAN_W-1:0] list_head     [scba_pkg::NUM_CLASSES];
   bit                        list_head_ok  [scba_pkg::NUM_CLASSES];
   int                        carve_ptr = 0;

   outcome_type pending_outcomes[$];   // responses still owed by the DUT
   logic [15:0] live_blocks[$];        // payload offsets currently allocated
   logic [15:0] last_freed = '0;       // handy target for double frees
   int          mismatches = 0;
   bit          tx_calm = 1'b0;        // back-to-back request stretch
   bit          rx_calm = 1'b0;        // always-ready response stretch

   size_class_bucket_allocator u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_req_bytes      (req_req_bytes),
      .req_payload_offset (req_payload_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_size_class     (rsp_size_class)
   );

   always #6 clock = ~clock;

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("tb: mismatch at %0t: %s", $realtime, msg);
   endtask

   function automatic void claim_granule(input int gran, input int cls);
      gran_tag[gran]     = scba_pkg::TAG_USED;
      gran_cls[gran]     = 4'(cls);
      gran_link[gran]    = '0;
      gran_link_ok[gran] = 1'b0;
   endfunction

   // Applies one request to the mirror and returns the response it owes.
   function automatic outcome_type predict_outcome(input logic op, input logic [15:0] nbytes,
                                                   input logic [15:0] poff);
      outcome_type res;
      int          total;
      int          cls;
      int          slot;
      int          gran;
      int          start;
      res = '0;
      if (op == scba_pkg::OP_ALLOC) begin
         if (nbytes == 0) begin
            res.status = scba_pkg::ST_ZERO_SIZE;
         end else begin
            total = int'(nbytes) + scba_pkg::HEADER_BYTES;
            cls = scba_pkg::NUM_CLASSES;
            for (int c = scba_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
               if ((16 << c) >= total) cls = c;
            end
            if (cls == scba_pkg::NUM_CLASSES) begin
               res.status = scba_pkg::ST_TOO_LARGE;
            end else begin
               slot = 16 << cls;
               res.cls = 4'(cls);
               if (list_head_ok[cls]) begin
                  // LIFO pop of the class free list
                  gran = int'(list_head[cls]);
                  list_head[cls]    = gran_link[gran];
                  list_head_ok[cls] = gran_link_ok[gran];
                  claim_granule(gran, cls);
                  res.offset = 16'(gran * 16 + scba_pkg::HEADER_BYTES);
               end else if (carve_ptr + slot <= EFF_POOL) begin
                  gran = carve_ptr / 16;
                  carve_ptr += slot;
                  claim_granule(gran, cls);
                  res.offset = 16'(gran * 16 + scba_pkg::HEADER_BYTES);
               end else begin
                  res.status = scba_pkg::ST_EXHAUSTED;
               end
            end
         end
      end else if (poff != 0) begin
         if (int'(poff) < scba_pkg::HEADER_BYTES) begin
            res.status = scba_pkg::ST_BAD_PTR;
         end else begin
            start = int'(poff) - scba_pkg::HEADER_BYTES;
            gran  = start / 16;
            if ((start % 16) != 0 || gran >= scba_pkg::GRANULES ||
                gran_tag[gran] != scba_pkg::TAG_USED ||
                gran_cls[gran] >= scba_pkg::NUM_CLASSES) begin
               res.status = scba_pkg::ST_BAD_PTR;
            end else begin
               cls = int'(gran_cls[gran]);
               gran_tag[gran]     = scba_pkg::TAG_FREE;
               gran_link[gran]    = list_head[cls];
               gran_link_ok[gran] = list_head_ok[cls];
               list_head[cls]     = scba_pkg::GRAN_W'(gran);
               list_head_ok[cls]  = 1'b1;
               res.cls = 4'(cls);
            end
         end
      end
      return res;
   endfunction

   // Random payload size that lands in class cls (classes 0 and 1 can't hold a header).
   function automatic logic [15:0] size_for_class(input int cls);
      int lo;
      int hi;
      lo = (cls <= 2) ? 1 : (16 << (cls - 1)) - scba_pkg::HEADER_BYTES + 1;
      hi = (16 << cls) - scba_pkg::HEADER_BYTES;
      return 16'($urandom_range(lo, hi));
   endfunction

   // Drives one request transaction; arg is the size for an allocate, the offset for a free.
   // The unused field carries random bits. Valid is only lowered when a gap is drawn.
   task automatic send_request(input logic op, input logic [15:0] arg,
                               output outcome_type want);
      int          gap;
      logic [15:0] nbytes;
      logic [15:0] poff;
      nbytes = (op == scba_pkg::OP_ALLOC) ? arg : 16'($urandom);
      poff   = (op == scba_pkg::OP_FREE) ? arg : 16'($urandom);
      gap = tx_calm ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_op             <= op;
      req_req_bytes      <= nbytes;
      req_payload_offset <= poff;
      do @(posedge clock); while (req_ready !== 1'b1);
      // accepted at this edge
      want = predict_outcome(op, nbytes, poff);
      pending_outcomes.push_back(want);
      if (want.status == scba_pkg::ST_OK) begin
         if (op == scba_pkg::OP_ALLOC) begin
            live_blocks.push_back(want.offset);
         end else if (poff != 0) begin
            last_freed = poff;
            for (int i = 0; i < live_blocks.size(); i++) begin
               if (live_blocks[i] == poff) begin
                  live_blocks.delete(i);
                  break;
               end
            end
         end
      end
   endtask

   // One random transaction: mostly well-formed allocs and frees, about 5% malformed.
   task automatic send_random_item(input int alloc_pct, input int lo_cls, input int hi_cls);
      int          roll;
      logic [15:0] victim;
      outcome_type got;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         case ($urandom_range(0, 4))
            0: send_request(scba_pkg::OP_FREE, 16'($urandom), got);
            1: send_request(scba_pkg::OP_ALLOC, 16'($urandom), got);
            2: send_request(scba_pkg::OP_FREE, last_freed, got);
            3: begin
               victim = (live_blocks.size() != 0) ?
                        live_blocks[$urandom_range(0, live_blocks.size() - 1)] : 16'h0100;
               send_request(scba_pkg::OP_FREE, victim + 16'($urandom_range(1, 15)), got);
            end
            default: send_request(scba_pkg::OP_ALLOC, ($urandom_range(0, 1) != 0) ? 16'd0 :
                                  16'($urandom_range(4065, 65535)), got);
         endcase
      end else if (roll < 5 + alloc_pct || live_blocks.size() == 0) begin
         send_request(scba_pkg::OP_ALLOC, size_for_class($urandom_range(lo_cls, hi_cls)), got);
      end else begin
         victim = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
         send_request(scba_pkg::OP_FREE, victim, got);
      end
   endtask

   // Size edges: zero, smallest, class boundaries, largest slot, too large.
   task automatic test_alloc_sizes();
      logic [15:0] sizes[7] = '{16'd0, 16'd1, 16'd32, 16'd33, 16'd4064, 16'd4065, 16'hFFFF};
      outcome_type got;
      foreach (sizes[i]) send_request(scba_pkg::OP_ALLOC, sizes[i], got);
   endtask

   // Null free, offset below the header, misaligned, never allocated, good and double free.
   task automatic test_free_checks();
      outcome_type got;
      logic [15:0] blk;
      send_request(scba_pkg::OP_FREE, 16'd0, got);
      send_request(scba_pkg::OP_FREE, 16'd16, got);
      send_request(scba_pkg::OP_ALLOC, 16'd100, got);
      blk = got.offset;
      send_request(scba_pkg::OP_FREE, blk + 16'd8, got);
      send_request(scba_pkg::OP_FREE, 16'hFFE0, got);
      send_request(scba_pkg::OP_FREE, blk, got);
      send_request(scba_pkg::OP_FREE, blk, got);
   endtask

   // Free list order: the last block freed is the first one handed out again.
   task automatic test_lifo_reuse();
      outcome_type got;
      logic [15:0] blk_a;
      logic [15:0] blk_b;
      send_request(scba_pkg::OP_ALLOC, 16'd100, got);
      blk_a = got.offset;
      send_request(scba_pkg::OP_ALLOC, 16'd100, got);
      blk_b = got.offset;
      send_request(scba_pkg::OP_FREE, blk_a, got);
      send_request(scba_pkg::OP_FREE, blk_b, got);
      send_request(scba_pkg::OP_ALLOC, 16'd100, got);
      send_request(scba_pkg::OP_ALLOC, 16'd100, got);
      // slot at the very start of the pool
      send_request(scba_pkg::OP_FREE, 16'(scba_pkg::HEADER_BYTES), got);
      send_request(scba_pkg::OP_ALLOC, 16'd1, got);
   endtask

   task automatic test_random_small();
      repeat (350) send_random_item(60, 2, 4);
   endtask

   task automatic test_random_mixed();
      repeat (330) send_random_item(50, 2, 8);
   endtask

   // Big slots until the bump pointer runs dry, then alloc-heavy traffic on a full pool.
   task automatic test_pool_exhaustion();
      outcome_type got;
      int          hits;
      hits = 0;
      for (int n = 0; n < 60 && hits < 4; n++) begin
         send_request(scba_pkg::OP_ALLOC, size_for_class($urandom_range(7, 8)), got);
         if (got.status == scba_pkg::ST_EXHAUSTED) hits++;
      end
      repeat (120) send_random_item(75, 2, 8);
   endtask

   // Return every live block, then pull a few back off the lists.
   task automatic test_drain();
      outcome_type got;
      while (live_blocks.size() != 0) begin
         send_request(scba_pkg::OP_FREE,
                      live_blocks[$urandom_range(0, live_blocks.size() - 1)], got);
      end
      repeat (12) send_request(scba_pkg::OP_ALLOC, size_for_class($urandom_range(2, 8)), got);
   endtask

   // Response side: random ready stalls, each transaction checked against the oldest
   // expectation. Ready stays high from one transaction to the next when no stall is drawn.
   initial begin
      int          stall;
      outcome_type want;
      while (reset) @(negedge clock);
      forever begin
         stall = rx_calm ? 0 : $urandom_range(0, 11);
         if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("response with no request outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               flag_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
            end
            if (rsp_granted_offset !== want.offset) begin
               flag_mismatch($sformatf("granted_offset got %0d want %0d",
                                       rsp_granted_offset, want.offset));
            end
            if (rsp_size_class !== want.cls) begin
               flag_mismatch($sformatf("size_class got %0d want %0d",
                                       rsp_size_class, want.cls));
            end
         end
      end
   end

   // Stimulus sequence. The first request waits out the post-reset tag clear on req_ready.
   initial begin
      int waited;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_alloc_sizes();
      test_free_checks();
      test_lifo_reuse();
      test_random_small();
      test_random_mixed();
      test_pool_exhaustion();
      test_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_outcomes.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      // keep running to catch any stray response
      repeat (10) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         flag_mismatch($sformatf("%0d responses never arrived", pending_outcomes.size()));
      end
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: ends a run that hangs with a failure.
   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

endmodule
